FILE: hdl/psr_pkg.sv
// Shared types, widths and constants of the PID speed regulator.
package psr_pkg;

  localparam int DATA_W = 16;  // gains, setpoint, limits and speed samples
  localparam int IDX_W  = 3;   // configuration register index
  localparam int ERR_W  = 17;  // target minus measured speed
  localparam int ACC_W  = 18;  // integral before clamping
  localparam int DIF_W  = 18;  // error difference for the derivative term
  localparam int P_W    = 33;
  localparam int I_W    = 32;
  localparam int D_W    = 34;
  localparam int SUM_W  = 36;  // Q.8 sum of the three terms
  localparam int QS_W   = 24;  // clamped Q.8 sum
  localparam int SHR_W  = 15;  // magnitude after dropping the low 9 bits
  localparam int RCP_W  = 16;
  localparam int PROD_W = SHR_W + RCP_W;
  localparam int DRV_W  = 13;
  localparam int MAG_W  = 12;
  localparam int Q_FRAC = 8;

  // Division by 2560 is a shift by 9 (512) followed by a division by 5,
  // done as a multiplication by ceil(2^18 / 5) and a shift by 18. This is
  // exact for every dividend below 2^16.
  localparam int                 SCALE_SHIFT = 9;
  localparam int                 RCP_SHIFT   = 18;
  localparam logic [RCP_W-1:0]   RCP_FIVE    = 16'd52429;

  localparam logic [IDX_W-1:0] REG_KP     = 3'd0;
  localparam logic [IDX_W-1:0] REG_KI     = 3'd1;
  localparam logic [IDX_W-1:0] REG_KD     = 3'd2;
  localparam logic [IDX_W-1:0] REG_TARGET = 3'd3;
  localparam logic [IDX_W-1:0] REG_LO     = 3'd4;
  localparam logic [IDX_W-1:0] REG_HI     = 3'd5;

  localparam logic signed [DATA_W-1:0] LIMIT_LO_RST = -16'sd1000;
  localparam logic signed [DATA_W-1:0] LIMIT_HI_RST = 16'sd1000;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BWD  = 2'd2
  } dir_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki;
    logic signed [DATA_W-1:0] kd;
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] lim_lo;
    logic signed [DATA_W-1:0] lim_hi;
  } psr_cfg_t;

endpackage

FILE: hdl/pid_speed_regulator_top.sv
// Top level of the positional PID speed regulator for one wheel.
// Throughput: one sample per cycle; a result held by the consumer stalls the whole pipeline.
// Reset clears the gains and setpoint, sets the limits to -1000 and 1000,
// clears the integral and the previous error, and empties the pipeline.
module pid_speed_regulator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [psr_pkg::IDX_W-1:0]           cfg_index,
  input  logic [psr_pkg::DATA_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [psr_pkg::DATA_W-1:0]   measured_speed,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [psr_pkg::DRV_W-1:0]    drive_value,
  output logic [1:0]                          direction,
  output logic [psr_pkg::MAG_W-1:0]           magnitude
);
  import psr_pkg::*;

  // The pipeline has five register stages:
  //   1. error, clamped integral and error difference (this stage also
  //      holds the loop state, which is updated on every input transfer),
  //   2. the three gain products,
  //   3. the clamped Q.8 sum,
  //   4. the reciprocal product for the division by 2560 and the direction,
  //   5. the result register that drives the output channel.
  // All stages advance together whenever the result register is empty or
  // its transfer completes, so a new sample can enter on every cycle.

  psr_cfg_t                 cfg;
  logic                     adv;
  logic                     take;
  logic [3:0]               stage_valid;
  logic signed [ERR_W-1:0]  last_error;
  logic signed [DATA_W-1:0] error_sum;
  logic signed [DIF_W-1:0]  err_dif;
  logic signed [P_W-1:0]    p_term;
  logic signed [I_W-1:0]    i_term;
  logic signed [D_W-1:0]    d_term;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign take     = in_valid && adv;

  // Valid bits follow the data through the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else if (adv) begin
      stage_valid <= {stage_valid[2:0], in_valid};
      out_valid   <= stage_valid[3];
    end
  end

  psr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The previous error register doubles as this sample's error for the
  // proportional product, since it is loaded with the error on each transfer.
  psr_error_unit u_err (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .measured_speed (measured_speed),
    .cfg            (cfg),
    .last_error     (last_error),
    .error_sum      (error_sum),
    .err_dif        (err_dif)
  );

  psr_term_mult u_mult (
    .clk       (clk),
    .adv       (adv),
    .cfg       (cfg),
    .err       (last_error),
    .error_sum (error_sum),
    .err_dif   (err_dif),
    .p_term    (p_term),
    .i_term    (i_term),
    .d_term    (d_term)
  );

  psr_drive_scale u_scale (
    .clk         (clk),
    .adv         (adv),
    .cfg         (cfg),
    .p_term      (p_term),
    .i_term      (i_term),
    .d_term      (d_term),
    .drive_value (drive_value),
    .direction   (direction),
    .magnitude   (magnitude)
  );

endmodule

FILE: hdl/psr_cfg_regs.sv
// Configuration register bank of the PID speed regulator.
module psr_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [psr_pkg::IDX_W-1:0]    cfg_index,
  input  logic [psr_pkg::DATA_W-1:0]   cfg_data,
  output psr_pkg::psr_cfg_t            cfg
);
  import psr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp     <= '0;
      cfg.ki     <= '0;
      cfg.kd     <= '0;
      cfg.target <= '0;
      cfg.lim_lo <= LIMIT_LO_RST;
      cfg.lim_hi <= LIMIT_HI_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KP:     cfg.kp     <= cfg_data;
        REG_KI:     cfg.ki     <= cfg_data;
        REG_KD:     cfg.kd     <= cfg_data;
        REG_TARGET: cfg.target <= cfg_data;
        REG_LO:     cfg.lim_lo <= cfg_data;
        REG_HI:     cfg.lim_hi <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/psr_error_unit.sv
// Error, clamped integral and error difference, with the loop state.
module psr_error_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic signed [psr_pkg::DATA_W-1:0]   measured_speed,
  input  psr_pkg::psr_cfg_t                   cfg,
  output logic signed [psr_pkg::ERR_W-1:0]    last_error,
  output logic signed [psr_pkg::DATA_W-1:0]   error_sum,
  output logic signed [psr_pkg::DIF_W-1:0]    err_dif
);
  import psr_pkg::*;

  logic signed [ERR_W-1:0]  err;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  lo_ext;
  logic signed [ACC_W-1:0]  hi_ext;
  logic signed [ACC_W-1:0]  acc_hi;
  logic signed [ACC_W-1:0]  acc_lo;
  logic signed [DATA_W-1:0] error_sum_next;
  logic signed [DIF_W-1:0]  err_dif_next;

  always_comb begin
    err    = {cfg.target[DATA_W-1], cfg.target} - {measured_speed[DATA_W-1], measured_speed};
    acc    = {{(ACC_W-DATA_W){error_sum[DATA_W-1]}}, error_sum}
           + {{(ACC_W-ERR_W){err[ERR_W-1]}}, err};
    lo_ext = {{(ACC_W-DATA_W){cfg.lim_lo[DATA_W-1]}}, cfg.lim_lo};
    hi_ext = {{(ACC_W-DATA_W){cfg.lim_hi[DATA_W-1]}}, cfg.lim_hi};
    // Upper bound is tested first, so crossed limits settle on the lower one.
    acc_hi = (acc > hi_ext) ? hi_ext : acc;
    acc_lo = (acc_hi < lo_ext) ? lo_ext : acc_hi;
    error_sum_next = acc_lo[DATA_W-1:0];
    err_dif_next   = {{(DIF_W-ERR_W){err[ERR_W-1]}}, err}
                   - {{(DIF_W-ERR_W){last_error[ERR_W-1]}}, last_error};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (take) begin
      error_sum  <= error_sum_next;
      last_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      err_dif <= err_dif_next;
    end
  end

endmodule

FILE: hdl/psr_term_mult.sv
// Registered P, I and D products in Q.8.
module psr_term_mult (
  input  logic                                clk,
  input  logic                                adv,
  input  psr_pkg::psr_cfg_t                   cfg,
  input  logic signed [psr_pkg::ERR_W-1:0]    err,
  input  logic signed [psr_pkg::DATA_W-1:0]   error_sum,
  input  logic signed [psr_pkg::DIF_W-1:0]    err_dif,
  output logic signed [psr_pkg::P_W-1:0]      p_term,
  output logic signed [psr_pkg::I_W-1:0]      i_term,
  output logic signed [psr_pkg::D_W-1:0]      d_term
);
  import psr_pkg::*;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_term <= P_W'($signed(cfg.kp)) * P_W'(err);
      i_term <= I_W'($signed(cfg.ki)) * I_W'(error_sum);
      d_term <= D_W'($signed(cfg.kd)) * D_W'(err_dif);
    end
  end

endmodule

FILE: hdl/psr_drive_scale.sv
// Sum and clamp of the terms, scaling by 1/2560 and the drive result register.
module psr_drive_scale (
  input  logic                                clk,
  input  logic                                adv,
  input  psr_pkg::psr_cfg_t                   cfg,
  input  logic signed [psr_pkg::P_W-1:0]      p_term,
  input  logic signed [psr_pkg::I_W-1:0]      i_term,
  input  logic signed [psr_pkg::D_W-1:0]      d_term,
  output logic signed [psr_pkg::DRV_W-1:0]    drive_value,
  output logic [1:0]                          direction,
  output logic [psr_pkg::MAG_W-1:0]           magnitude
);
  import psr_pkg::*;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] lo_q;
  logic signed [SUM_W-1:0] hi_q;
  logic signed [SUM_W-1:0] sum_hi;
  logic signed [SUM_W-1:0] sum_lo;
  logic signed [QS_W-1:0]  qsum;
  logic [QS_W-1:0]         qabs;
  logic [SHR_W-1:0]        qshr;
  logic [PROD_W-1:0]       prod;
  dir_t                    dir_s4;
  dir_t                    dir_s4_next;
  logic [DRV_W-1:0]        quo;

  always_comb begin
    sum  = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);
    lo_q = {{(SUM_W-DATA_W-Q_FRAC){cfg.lim_lo[DATA_W-1]}}, cfg.lim_lo, {Q_FRAC{1'b0}}};
    hi_q = {{(SUM_W-DATA_W-Q_FRAC){cfg.lim_hi[DATA_W-1]}}, cfg.lim_hi, {Q_FRAC{1'b0}}};
    sum_hi = (sum > hi_q) ? hi_q : sum;
    sum_lo = (sum_hi < lo_q) ? lo_q : sum_hi;
  end

  // Magnitude of the clamped sum; the most negative value maps to 2^23.
  always_comb begin
    qabs = qsum[QS_W-1] ? QS_W'(-qsum) : QS_W'(qsum);
    qshr = qabs[QS_W-1:SCALE_SHIFT];
    if (qsum == '0) begin
      dir_s4_next = DIR_STOP;
    end else if (qsum[QS_W-1]) begin
      dir_s4_next = DIR_BWD;
    end else begin
      dir_s4_next = DIR_FWD;
    end
    quo = prod[PROD_W-1:RCP_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qsum   <= sum_lo[QS_W-1:0];
      prod   <= PROD_W'(qshr) * PROD_W'(RCP_FIVE);
      dir_s4 <= dir_s4_next;
      direction   <= dir_s4;
      magnitude   <= quo[MAG_W-1:0];
      drive_value <= (dir_s4 == DIR_BWD) ? DRV_W'(-quo) : quo;
    end
  end

endmodule
